@@ hw/rtl/rational_arith_reduce_defines.svh @@
// Assertion macros used by the checker file of rational_arith_reduce.
// Depends on nothing; expects clk_i and rst_ni in the scope of each use.
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define RAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define RAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/rar_pkg.sv @@
// Types and constants of the rational arithmetic reducer.
// Used by rar_div, rational_arith_reduce and rar_checker; depends on nothing.
`default_nettype none

package rar_pkg;

  localparam int unsigned RAR_WIDTH = 32;  // operand bits taken from each field
  localparam int unsigned RAR_MAG_W = 64;  // product, sum and GCD magnitude width

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rar_op_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rar_in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               status;
  } rar_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/rar_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on rar_pkg for the default width.
`default_nettype none

module rar_div #(
  parameter int unsigned DW = rar_pkg::RAR_MAG_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW:0]   rem_q, rem_d, rem_sh;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] dsr_q, dsr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic          ge;

  assign rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = CW'(DW);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_d  = {quo_q[DW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/rational_arith_reduce.sv @@
// Sequence: S_MUL0 to S_MUL2 multiply, S_SUM adds, S_GCD runs the binary GCD,
// S_DIVN and S_DIVD divide numerator and denominator by it on the shared
// bit-serial divider (two 64-bit divisions), S_WAIT hands the result out; a zero
// numerator or denominator skips from S_SUM to S_WAIT. One beat at a time; a new
// beat is taken as soon as the sequencer is back to idle, even while the last
// result waits. Reset (async, active low) returns to idle with no result pending.
`default_nettype none

module rational_arith_reduce #(
  parameter int unsigned WIDTH = rar_pkg::RAR_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rar_pkg::rar_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rar_pkg::rar_out_t out_data_o
);

  import rar_pkg::*;

  localparam int unsigned MW = RAR_MAG_W;
  localparam int unsigned KW = $clog2(MW);

  // One-hot sequencer.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_SUM  = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIVN = 9'b001000000,
    S_DIVD = 9'b010000000,
    S_WAIT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Operands in sign/magnitude form, captured on the input beat.
  logic [1:0]       op_q;
  logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic             an_s_q, ad_s_q, bn_s_q, bd_s_q;

  logic [WIDTH-1:0] an_raw, ad_raw, bn_raw, bd_raw;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic             an_s, ad_s, bn_s, bd_s;

  assign an_raw = in_data_i.a_num[WIDTH-1:0];
  assign ad_raw = in_data_i.a_den[WIDTH-1:0];
  assign bn_raw = in_data_i.b_num[WIDTH-1:0];
  assign bd_raw = in_data_i.b_den[WIDTH-1:0];
  assign an_s   = an_raw[WIDTH-1];
  assign ad_s   = ad_raw[WIDTH-1];
  assign bn_s   = bn_raw[WIDTH-1];
  assign bd_s   = bd_raw[WIDTH-1];
  // Most negative value negates to itself, which reads as 2^(WIDTH-1) unsigned.
  assign an_m   = an_s ? (~an_raw + WIDTH'(1)) : an_raw;
  assign ad_m   = ad_s ? (~ad_raw + WIDTH'(1)) : ad_raw;
  assign bn_m   = bn_s ? (~bn_raw + WIDTH'(1)) : bn_raw;
  assign bd_m   = bd_s ? (~bd_raw + WIDTH'(1)) : bd_raw;

  // Shared multiplier, result registered into the product slot of the state.
  //   add/sub: P0 = an*bd, P1 = ad*bn, P2 = ad*bd
  //   mul:     P0 = an*bn,             P2 = ad*bd
  //   div:     P0 = an*bd,             P2 = ad*bn
  logic [WIDTH-1:0]   mul_a, mul_b;
  logic               mul_s;
  logic [2*WIDTH-1:0] mul_p;
  logic [MW-1:0]      mul_m;
  logic               mul_neg;

  always_comb begin
    mul_a = ad_q;
    mul_b = bd_q;
    mul_s = ad_s_q ^ bd_s_q;
    unique case (state_q)
      S_MUL0: begin
        mul_a = an_q;
        mul_b = (op_q == OP_MUL) ? bn_q : bd_q;
        mul_s = an_s_q ^ ((op_q == OP_MUL) ? bn_s_q : bd_s_q);
      end
      S_MUL1: begin
        mul_a = ad_q;
        mul_b = bn_q;
        mul_s = ad_s_q ^ bn_s_q;
      end
      S_MUL2: begin
        mul_a = ad_q;
        mul_b = (op_q == OP_DIV) ? bn_q : bd_q;
        mul_s = ad_s_q ^ ((op_q == OP_DIV) ? bn_s_q : bd_s_q);
      end
      default: begin
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_m   = MW'(mul_p);
  assign mul_neg = mul_s && (mul_p != '0);

  logic [MW-1:0] p0_q, p1_q, p2_q;
  logic          p0_s_q, p1_s_q, p2_s_q;

  // Signed sum in sign/magnitude; both sides are below 2^63 so 64 bits hold it.
  logic [MW-1:0] n_m, d_m;
  logic          n_s, d_s;

  always_comb begin
    d_m = p2_q;
    d_s = p2_s_q;
    n_m = p0_q;
    n_s = p0_s_q;
    if (op_q == OP_ADD || op_q == OP_SUB) begin
      if (p0_s_q == p1_s_q) begin
        n_m = p0_q + p1_q;
        n_s = p0_s_q;
      end else if (p0_q >= p1_q) begin
        n_m = p0_q - p1_q;
        n_s = p0_s_q;
      end else begin
        n_m = p1_q - p0_q;
        n_s = p1_s_q;
      end
      if (n_m == '0) begin
        n_s = 1'b0;
      end
    end
  end

  // Fraction held through the GCD and the divisions.
  logic [MW-1:0] nm_q, dm_q, g_q, qn_q;
  logic          neg_q;

  // Binary GCD state: both halved while even, common factor counted in gk.
  logic [MW-1:0] gx_q, gx_d, gy_q, gy_d;
  logic [KW-1:0] gk_q, gk_d;
  logic [MW-1:0] g_w;

  assign g_w = (gx_q | gy_q) << gk_q;

  always_comb begin
    gx_d = gx_q;
    gy_d = gy_q;
    gk_d = gk_q;
    if (!gx_q[0] && !gy_q[0]) begin
      gx_d = gx_q >> 1;
      gy_d = gy_q >> 1;
      gk_d = gk_q + KW'(1);
    end else if (!gx_q[0]) begin
      gx_d = gx_q >> 1;
    end else if (!gy_q[0]) begin
      gy_d = gy_q >> 1;
    end else if (gx_q >= gy_q) begin
      gx_d = gx_q - gy_q;
    end else begin
      gy_d = gy_q - gx_q;
    end
  end

  // Divider shared by numerator and denominator.
  logic          div_start;
  logic [MW-1:0] div_dvd, div_dsr, div_quot;
  logic          div_done;

  rar_div #(
    .DW(MW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    div_start = 1'b0;
    div_dvd   = nm_q;
    div_dsr   = g_w;
    if (state_q == S_GCD && (gx_q == '0 || gy_q == '0)) begin
      div_start = 1'b1;
    end else if (state_q == S_DIVN && div_done) begin
      div_start = 1'b1;
      div_dvd   = dm_q;
      div_dsr   = g_q;
    end
  end

  // Staged result and output register.
  logic [MW-1:0]   sat_m;
  logic [MW-1:0]   snum;
  rar_out_t        res_q, res_d;
  rar_out_t        out_q;
  logic            out_vld_q, out_vld_d;
  logic            out_load;

  // A quotient of 2^63 only arises from a numerator of 2^63 with g = 1.
  assign sat_m = qn_q[MW-1] ? {1'b0, {(MW-1){1'b1}}} : qn_q;
  assign snum  = neg_q ? (~sat_m + MW'(1)) : sat_m;

  always_comb begin
    res_d = res_q;
    if (state_q == S_SUM) begin
      if (d_m == '0) begin
        res_d.res_num = '0;
        res_d.res_den = '0;
        res_d.status  = 1'b1;
      end else begin
        res_d.res_num = '0;
        res_d.res_den = 63'(1);
        res_d.status  = 1'b0;
      end
    end else if (state_q == S_DIVD && div_done) begin
      res_d.res_num = snum;
      res_d.res_den = div_quot[62:0];
      res_d.status  = 1'b0;
    end
  end

  assign out_load  = (state_q == S_WAIT) && (!out_vld_q || !out_stall_i);
  assign out_vld_d = out_load || (out_vld_q && out_stall_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL0;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_SUM;
      S_SUM: begin
        if (d_m == '0 || n_m == '0) begin
          state_d = S_WAIT;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD:  if (div_start) state_d = S_DIVN;
      S_DIVN: if (div_done) state_d = S_DIVD;
      S_DIVD: if (div_done) state_d = S_WAIT;
      S_WAIT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q   <= in_data_i.opcode;
      an_q   <= an_m;
      ad_q   <= ad_m;
      bn_q   <= bn_m;
      bd_q   <= bd_m;
      an_s_q <= an_s;
      ad_s_q <= ad_s;
      bd_s_q <= bd_s;
      // Subtract flips the second numerator's sign.
      bn_s_q <= (in_data_i.opcode == OP_SUB) ? (!bn_s && bn_m != '0) : bn_s;
    end
    if (state_q == S_MUL0) begin
      p0_q   <= mul_m;
      p0_s_q <= mul_neg;
    end
    if (state_q == S_MUL1) begin
      p1_q   <= mul_m;
      p1_s_q <= mul_neg;
    end
    if (state_q == S_MUL2) begin
      p2_q   <= mul_m;
      p2_s_q <= mul_neg;
    end
    if (state_q == S_SUM) begin
      nm_q  <= n_m;
      dm_q  <= d_m;
      neg_q <= n_s ^ d_s;
      gx_q  <= n_m;
      gy_q  <= d_m;
      gk_q  <= '0;
    end
    if (state_q == S_GCD) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
      gk_q <= gk_d;
      if (div_start) begin
        g_q <= g_w;
      end
    end
    if (state_q == S_DIVN && div_done) begin
      qn_q <= div_quot;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/rar_checker.sv @@
// Port-level checks for rational_arith_reduce, bound to the top level.
// Depends on rar_pkg and rational_arith_reduce_defines.svh.
`default_nettype none

`include "rational_arith_reduce_defines.svh"

module rar_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  rar_pkg::rar_in_t  in_data_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  rar_pkg::rar_out_t out_data_o
);

  import rar_pkg::*;

  `RAR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result beat changed")
  `RAR_ASSERT(a_err_zero, out_valid_o && out_data_o.status |-> out_data_o.res_num == '0 && out_data_o.res_den == '0, "error beat not 0/0")
  `RAR_ASSERT(a_den_pos, out_valid_o && !out_data_o.status |-> out_data_o.res_den != '0, "zero denominator without error")
  `RAR_ASSERT(a_zero_one, out_valid_o && !out_data_o.status && out_data_o.res_num == '0 |-> out_data_o.res_den == 63'(1), "zero not reduced to 0/1")
  `RAR_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "result beat during reset")

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);

`default_nettype wire
